// File: design/stff_pkg.sv
// ----------------------------------------------------------------------------
// stff_pkg: shared types and constants for the slot table
// Sizes, action and status codes, and the command/status structs that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package stff_pkg;

	localparam int SLOTS    = 64;
	localparam int HANDLE_W = 16;
	localparam int POS_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);
	localparam int ACT_W    = 3;
	localparam int STAT_W   = 2;

	// free-slot search: groups of GRP slots, encoded per group, then across groups
	localparam int GRP    = 8;
	localparam int GRP_W  = $clog2(GRP);
	localparam int NGRP   = SLOTS / GRP;
	localparam int NGRP_W = $clog2(NGRP);

	localparam int IN_BITS  = ACT_W + 2 * POS_W + HANDLE_W + 1;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = HANDLE_W + 1 + STAT_W + POS_W + 2 * CNT_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam logic [CNT_W-1:0] MAX_SLOTS_RST = CNT_W'(64);

	localparam logic [ACT_W-1:0] ACT_READ  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_WRITE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_PUSH  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_SWAP  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef enum logic [1:0] {
		CS_IDLE,
		CS_EXEC,
		CS_SWAP2
	} ctrl_state_t;

	typedef struct packed {
		logic load;    // capture a word, read memory, encode free groups
		logic commit;  // apply the action and fill the result register
		logic wr2;     // second memory write of a swap
	} dp_cmd_t;

	typedef struct packed {
		logic need_wr2;
	} dp_sts_t;

endpackage

// File: design/stff_ctrl.sv
// ----------------------------------------------------------------------------
// stff_ctrl: slot table controller
// Sequences accept, execute and the optional second swap write, and owns
// the output valid flag.
// ----------------------------------------------------------------------------
module stff_ctrl
	import stff_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			CS_IDLE: begin
				if (in_valid) state_nxt = CS_EXEC;
			end
			CS_EXEC: begin
				// hold until the result register can take the word
				if (out_free) state_nxt = sts.need_wr2 ? CS_SWAP2 : CS_IDLE;
			end
			CS_SWAP2: state_nxt = CS_IDLE;
			default:  state_nxt = CS_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		cmd.wr2    = 1'b0;
		case (state_q)
			CS_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			CS_EXEC:  cmd.commit = out_free;
			CS_SWAP2: cmd.wr2 = 1'b1;
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// File: design/stff_dp.sv
// ----------------------------------------------------------------------------
// stff_dp: slot table datapath
// Handle memory, occupancy bits and count, limit register, two-level
// free-slot search and the result register.
// ----------------------------------------------------------------------------
module stff_dp
	import stff_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_sts_t             sts,
	input  logic                cfg_valid,
	input  logic [CNT_W-1:0]    cfg_data,
	input  logic [ACT_W-1:0]    action,
	input  logic [POS_W-1:0]    pos_a,
	input  logic [POS_W-1:0]    pos_b,
	input  logic [HANDLE_W-1:0] item_handle,
	input  logic                item_valid,
	output logic [HANDLE_W-1:0] out_handle,
	output logic                out_valid,
	output logic [STAT_W-1:0]   status,
	output logic [POS_W-1:0]    placed_pos,
	output logic [CNT_W-1:0]    used_slots,
	output logic [CNT_W-1:0]    free_slots
);

	logic [HANDLE_W-1:0] mem [SLOTS];

	logic [SLOTS-1:0]    full_q, full_nxt;
	logic [CNT_W-1:0]    cnt_q, cnt_nxt;
	logic [CNT_W-1:0]    max_slots_q;
	logic [CNT_W-1:0]    lim;

	logic [ACT_W-1:0]    action_q;
	logic [POS_W-1:0]    pa_q, pb_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                valid_q;
	logic                fa_q, fb_q;
	logic [HANDLE_W-1:0] rd_a_q, rd_b_q;
	logic [NGRP-1:0]     grp_any_q, grp_any;
	logic [GRP_W-1:0]    grp_idx_q [NGRP];
	logic [GRP_W-1:0]    grp_idx [NGRP];

	logic [HANDLE_W-1:0] oh;
	logic                ov;
	logic [STAT_W-1:0]   st;
	logic [POS_W-1:0]    placed;
	logic                found;
	logic [POS_W-1:0]    first_free;
	logic                pa_ok, pb_ok;
	logic                wr_en;
	logic [POS_W-1:0]    wr_addr;
	logic [HANDLE_W-1:0] wr_data;
	logic                mem_we;
	logic [POS_W-1:0]    mem_addr;
	logic [HANDLE_W-1:0] mem_wdata;

	assign lim = (max_slots_q < CNT_W'(SLOTS)) ? max_slots_q : CNT_W'(SLOTS);

	// first level of the free search: lowest free slot below the limit per group
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_any[g] = 1'b0;
			grp_idx[g] = '0;
			for (int j = GRP - 1; j >= 0; j--) begin
				if (!full_q[g*GRP + j] && (CNT_W'(g*GRP + j) < lim)) begin
					grp_any[g] = 1'b1;
					grp_idx[g] = GRP_W'(j);
				end
			end
		end
	end

	// second level: lowest group with a free slot
	always_comb begin
		found      = 1'b0;
		first_free = '0;
		for (int g = NGRP - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				found      = 1'b1;
				first_free = {NGRP_W'(g), grp_idx_q[g]};
			end
		end
	end

	assign pa_ok = {1'b0, pa_q} < lim;
	assign pb_ok = {1'b0, pb_q} < lim;

	always_comb begin
		oh           = '0;
		ov           = 1'b0;
		st           = STAT_OK;
		placed       = '0;
		wr_en        = 1'b0;
		wr_addr      = pa_q;
		wr_data      = handle_q;
		full_nxt     = full_q;
		cnt_nxt      = cnt_q;
		sts.need_wr2 = 1'b0;
		case (action_q)
			ACT_READ: begin
				if (!pa_ok) st = STAT_RANGE;
				else if (fa_q) begin
					oh = rd_a_q;
					ov = 1'b1;
				end
			end
			ACT_WRITE: begin
				if (!pa_ok) st = STAT_RANGE;
				else begin
					if (fa_q) begin
						oh = rd_a_q;
						ov = 1'b1;
					end
					wr_en          = valid_q;
					full_nxt[pa_q] = valid_q;
					cnt_nxt        = cnt_q - CNT_W'(fa_q) + CNT_W'(valid_q);
				end
			end
			ACT_PUSH: begin
				if (valid_q) begin
					if (cnt_q >= lim || !found) st = STAT_FULL;
					else begin
						placed               = first_free;
						wr_en                = 1'b1;
						wr_addr              = first_free;
						full_nxt[first_free] = 1'b1;
						cnt_nxt              = cnt_q + CNT_W'(1);
					end
				end
			end
			ACT_SWAP: begin
				if (!pa_ok || !pb_ok) st = STAT_RANGE;
				else if (fa_q || fb_q) begin
					// slot b takes a now, slot a takes b on the next write
					wr_en          = 1'b1;
					wr_addr        = pb_q;
					wr_data        = rd_a_q;
					full_nxt[pb_q] = fa_q;
					full_nxt[pa_q] = fb_q;
					sts.need_wr2   = 1'b1;
				end
			end
			ACT_CLEAR: begin
				full_nxt = '0;
				cnt_nxt  = '0;
			end
			default: begin
				st = STAT_OK;
			end
		endcase
	end

	assign mem_we    = (cmd.commit && wr_en) || cmd.wr2;
	assign mem_addr  = cmd.wr2 ? pa_q : wr_addr;
	assign mem_wdata = cmd.wr2 ? rd_b_q : wr_data;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (cmd.load) begin
			rd_a_q <= mem[pos_a];
			rd_b_q <= mem[pos_b];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q  <= action;
			pa_q      <= pos_a;
			pb_q      <= pos_b;
			handle_q  <= item_handle;
			valid_q   <= item_valid;
			fa_q      <= full_q[pos_a];
			fb_q      <= full_q[pos_b];
			grp_any_q <= grp_any;
			grp_idx_q <= grp_idx;
		end
		if (cmd.commit) begin
			out_handle <= ov ? oh : '0;
			out_valid  <= ov;
			status     <= st;
			placed_pos <= placed;
			used_slots <= cnt_nxt;
			free_slots <= (lim > cnt_nxt) ? lim - cnt_nxt : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q      <= '0;
			cnt_q       <= '0;
			max_slots_q <= MAX_SLOTS_RST;
		end else begin
			if (cmd.commit) begin
				full_q <= full_nxt;
				cnt_q  <= cnt_nxt;
			end
			if (cfg_valid) max_slots_q <= cfg_data;
		end
	end

endmodule

// File: design/slot_table_first_free_core.sv
// Sequence: a word is accepted in idle, executed once the result register can
//   take it; the result word is then shown on the master side.
// Occupancy: one word at a time, accepted only in idle; a data-moving swap adds
//   a second-write state, since the handle memory has a single write port.
// Reset: clears occupancy, count and control, sets the slot limit to 64;
//   handle memory contents are not cleared.
// ----------------------------------------------------------------------------
// slot_table_first_free_core: slot table with first-free allocation
// Read, write, push, swap and clear on a table of item handles with a limit.
// ----------------------------------------------------------------------------
module slot_table_first_free_core
	import stff_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// action[2:0], pos_a[8:3], pos_b[14:9], item_handle[30:15], item_valid[31]
	input  logic [IN_W-1:0]  s_axis_tdata,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// out_handle[15:0], out_valid[16], status[18:17], placed_pos[24:19],
	// used_slots[31:25], free_slots[38:32], zero pad above
	output logic [OUT_W-1:0] m_axis_tdata,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	dp_cmd_t             cmd;
	dp_sts_t             sts;
	logic [HANDLE_W-1:0] out_handle;
	logic                out_valid;
	logic [STAT_W-1:0]   status;
	logic [POS_W-1:0]    placed_pos;
	logic [CNT_W-1:0]    used_slots;
	logic [CNT_W-1:0]    free_slots;

	assign cfg_ready = 1'b1;

	stff_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	stff_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.action      (s_axis_tdata[ACT_W-1:0]),
		.pos_a       (s_axis_tdata[ACT_W +: POS_W]),
		.pos_b       (s_axis_tdata[ACT_W+POS_W +: POS_W]),
		.item_handle (s_axis_tdata[ACT_W+2*POS_W +: HANDLE_W]),
		.item_valid  (s_axis_tdata[ACT_W+2*POS_W+HANDLE_W]),
		.out_handle  (out_handle),
		.out_valid   (out_valid),
		.status      (status),
		.placed_pos  (placed_pos),
		.used_slots  (used_slots),
		.free_slots  (free_slots)
	);

	assign m_axis_tdata = {{(OUT_W-OUT_BITS){1'b0}}, free_slots, used_slots, placed_pos,
		status, out_valid, out_handle};

endmodule

// File: design/stff_chk.sv
// ----------------------------------------------------------------------------
// stff_chk: port-level checker for the slot table
// Watches the stream and result fields over time; bound to the top level.
// ----------------------------------------------------------------------------
module stff_chk
	import stff_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             s_axis_tvalid,
	input logic             s_axis_tready,
	input logic             m_axis_tvalid,
	input logic             m_axis_tready,
	input logic [OUT_W-1:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second word accepted while one is in execution");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[18:17] != 2'b11)
		else $error("undefined status code");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[15:0] == '0)
		else $error("empty result carries a handle");

	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:25] <= 7'd64) && (m_axis_tdata[38:32] <= 7'd64))
		else $error("slot counts beyond table size");

endmodule

bind slot_table_first_free_core stff_chk u_stff_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
